/* rtl/core/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, the prime modulus, the Barrett constant and the
// controller-to-datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  localparam int unsigned BaseW  = 30;
  localparam int unsigned ExpW   = 63;
  localparam int unsigned InTdW  = 96;
  localparam int unsigned OutTdW = 32;

  localparam logic [BaseW-1:0] Modulus = 30'd1000000007;

  // Barrett reciprocal floor(2^60 / modulus), worked out at elaboration.
  localparam logic [63:0] MuWide    = 64'h1000_0000_0000_0000 / 64'd1000000007;
  localparam logic [30:0] BarrettMu = MuWide[30:0];

  // Destination register of a product leaving the multiplier.
  typedef enum logic {
    TAG_ACC = 1'b0,
    TAG_SQ  = 1'b1
  } tag_e;

  typedef struct packed {
    logic load;       // capture a new word and set up acc and sq
    logic issue_mul;  // start acc * sq
    logic issue_sqr;  // start sq * sq
    logic shift;      // drop the lowest exponent bit
    logic out_load;   // copy acc into the result register
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_bit0;
    logic busy;       // products still in flight
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/mexp_modmul.sv */
// ----------------------------------------------------------------------------
// Pipelined modular multiplier
// Five-stage Barrett multiplier: product, reciprocal estimate, quotient times
// modulus, remainder, and two correction subtractions.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_modmul
  import mexp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire tag_e             in_tag_i,
  input  wire logic [BaseW-1:0] a_i,
  input  wire logic [BaseW-1:0] b_i,
  output logic                  out_valid_o,
  output tag_e                  out_tag_o,
  output logic [BaseW-1:0]      out_res_o,
  output logic                  busy_o
);

  logic [4:0] v_q;
  tag_e       tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;

  logic [59:0] x1_q;
  logic [61:0] t2_q;
  logic [31:0] xlo2_q, xlo3_q;
  logic [31:0] qp3_q;
  logic [31:0] r4_q, r5_q;

  logic [59:0] x1_d;
  logic [61:0] t2_d;
  logic [30:0] q3;
  logic [60:0] qp_full;
  logic [31:0] r4_d, r5_d;
  logic [31:0] mod32;
  logic [31:0] r_fix;

  assign mod32   = {2'b00, Modulus};
  assign x1_d    = a_i * b_i;
  assign t2_d    = x1_q[59:29] * BarrettMu;
  assign q3      = t2_q[61:31];
  assign qp_full = q3 * Modulus;
  // The true remainder is below three times the modulus, so 32 bits hold it.
  assign r4_d    = xlo3_q - qp3_q;
  assign r5_d    = (r4_q >= mod32) ? (r4_q - mod32) : r4_q;
  assign r_fix   = (r5_q >= mod32) ? (r5_q - mod32) : r5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= x1_d;
    tag1_q <= in_tag_i;
    t2_q   <= t2_d;
    xlo2_q <= x1_q[31:0];
    tag2_q <= tag1_q;
    qp3_q  <= qp_full[31:0];
    xlo3_q <= xlo2_q;
    tag3_q <= tag2_q;
    r4_q   <= r4_d;
    tag4_q <= tag3_q;
    r5_q   <= r5_d;
    tag5_q <= tag4_q;
  end

  assign out_valid_o = v_q[4];
  assign out_tag_o   = tag5_q;
  assign out_res_o   = r_fix[BaseW-1:0];
  assign busy_o      = |v_q;

`ifndef ASSERT_OFF
  a_res_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (r_fix < mod32))
    else $error("modmul result not reduced");

  a_r5_below_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (r5_q < {mod32[30:0], 1'b0}))
    else $error("modmul remainder exceeds two moduli");
`endif

endmodule

`default_nettype wire

/* rtl/core/mexp_datapath.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the running result, the current power, the exponent and the result
// word, and feeds the shared modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_datapath
  import mexp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output status_t               status_o,
  input  wire logic [BaseW-1:0] base_i,
  input  wire logic [ExpW-1:0]  exponent_i,
  output logic [BaseW-1:0]      result_o
);

  logic [BaseW-1:0] acc_q, acc_d;
  logic [BaseW-1:0] sq_q, sq_d;
  logic [ExpW-1:0]  exp_q, exp_d;
  logic [BaseW-1:0] res_q, res_d;

  logic             mm_in_valid;
  tag_e             mm_in_tag;
  logic [BaseW-1:0] mm_a;
  logic             mm_out_valid;
  tag_e             mm_out_tag;
  logic [BaseW-1:0] mm_out_res;
  logic             mm_busy;
  logic [BaseW-1:0] base_red;

  // 2^30 is below twice the modulus, so one subtraction reduces the base.
  assign base_red = (base_i >= Modulus) ? (base_i - Modulus) : base_i;

  assign mm_in_valid = cmd_i.issue_mul | cmd_i.issue_sqr;
  assign mm_in_tag   = cmd_i.issue_mul ? TAG_ACC : TAG_SQ;
  assign mm_a        = cmd_i.issue_mul ? acc_q : sq_q;

  mexp_modmul u_modmul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mm_in_valid),
    .in_tag_i    (mm_in_tag),
    .a_i         (mm_a),
    .b_i         (sq_q),
    .out_valid_o (mm_out_valid),
    .out_tag_o   (mm_out_tag),
    .out_res_o   (mm_out_res),
    .busy_o      (mm_busy)
  );

  always_comb begin
    acc_d = acc_q;
    sq_d  = sq_q;
    exp_d = exp_q;
    res_d = res_q;
    if (cmd_i.load) begin
      acc_d = BaseW'(1);
      sq_d  = base_red;
      exp_d = exponent_i;
    end else begin
      if (mm_out_valid && (mm_out_tag == TAG_ACC)) begin
        acc_d = mm_out_res;
      end
      if (mm_out_valid && (mm_out_tag == TAG_SQ)) begin
        sq_d = mm_out_res;
      end
      if (cmd_i.shift) begin
        exp_d = {1'b0, exp_q[ExpW-1:1]};
      end
    end
    if (cmd_i.out_load) begin
      res_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sq_q  <= sq_d;
    exp_q <= exp_d;
    res_q <= res_d;
  end

  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_bit0 = exp_q[0];
  assign status_o.busy     = mm_busy;
  assign result_o          = res_q;

endmodule

`default_nettype wire

/* rtl/core/mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// One-hot state machine that walks the exponent bits, squares every round,
// multiplies when the bit is set, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl
  import mexp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_tvalid_i,
  output logic         s_tready_o,
  output logic         m_tvalid_o,
  input  wire logic    m_tready_i,
  output cmd_t         cmd_o,
  input  wire status_t status_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TEST = 5'b00010,
    S_SQR  = 5'b00100,
    S_WAIT = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~m_tready_i;
    cmd_o       = '0;
    s_tready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TEST;
        end
      end
      S_TEST: begin
        if (status_i.exp_zero) begin
          state_d = S_DONE;
        end else if (status_i.exp_bit0) begin
          cmd_o.issue_mul = 1'b1;
          state_d         = S_SQR;
        end else begin
          cmd_o.issue_sqr = 1'b1;
          cmd_o.shift     = 1'b1;
          state_d         = S_WAIT;
        end
      end
      S_SQR: begin
        cmd_o.issue_sqr = 1'b1;
        cmd_o.shift     = 1'b1;
        state_d         = S_WAIT;
      end
      S_WAIT: begin
        if (!status_i.busy) begin
          state_d = S_TEST;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !status_i.busy)
    else $error("multiplier busy while idle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_tready_i))
    else $error("result word overwritten before it was taken");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && s_tvalid_i) |=> (state_q == S_TEST))
    else $error("accepted word did not start a run");
`endif

endmodule

`default_nettype wire

/* rtl/core/modular_exponentiation_unit.sv */
// Operation: one round per exponent bit up to its highest set bit (the multiply
//   is skipped if the bit is clear), then a final test and the output register.
// Throughput: one word at a time; each round waits for the five-stage Barrett
//   multiplier to drain before the next exponent bit is tested.
// Reset: rst_ni is asynchronous and active low; it clears the state machine
//   and the pipeline valid bits. Data registers are not reset.
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Computes base to the power exponent modulo 1000000007 by right-to-left
// square-and-multiply on one shared pipelined modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_unit
  import mexp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [InTdW-1:0]  s_axis_tdata_i,   // [29:0] base, [92:30] exponent
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [OutTdW-1:0]      m_axis_tdata_o    // [29:0] result
);

  cmd_t             cmd;
  status_t          status;
  logic [BaseW-1:0] result;

  mexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  mexp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .base_i     (s_axis_tdata_i[BaseW-1:0]),
    .exponent_i (s_axis_tdata_i[BaseW+ExpW-1:BaseW]),
    .result_o   (result)
  );

  assign m_axis_tdata_o = {{(OutTdW-BaseW){1'b0}}, result};

endmodule

`default_nettype wire
